>>> rtl/rgbn_pkg.sv
// Shared constants and types for the RGB normalise and colour correct block.
package rgbn_pkg;

  localparam int unsigned INPUT_WIDTH_DEF = 16;
  localparam int unsigned CH_W            = 8;   // normalised channel width
  localparam int unsigned Y_W             = 11;  // B + 3G + R of 8-bit channels
  localparam int unsigned Z_W             = 10;  // 65535 / Y with Y >= 127
  localparam int unsigned REM_W           = 12;
  localparam int unsigned SC_W            = 10;  // bits 15..6 of the scaled channel
  localparam int unsigned DIV_STAGES      = 5;
  localparam int unsigned DIV_STEPS       = 2;   // quotient bits per divider stage
  localparam int unsigned DRV_W           = 8;

  // The top six dividend bits of 65535 leave this remainder, since Y is above it.
  localparam logic [REM_W-1:0] REM_INIT   = REM_W'(63);
  localparam logic [CH_W-1:0]  TOP_LOW    = CH_W'(127);

  typedef logic [15:0] word_t;
  typedef logic [CH_W-1:0] ch_t;

  // Mixing weights as 16-bit two's complement, rows red, green, blue drive.
  localparam word_t MIX_W [3][3] = '{
    '{16'd29,      16'hfffc,  16'hffff},
    '{16'hfffe,    16'd127,   16'hffe6},
    '{16'd1,       16'hffef,  16'd56}
  };

endpackage

>>> rtl/rgbn_div.sv
// Pipelined restoring divider that forms 65535 / y, two quotient bits a stage.
module rgbn_div (
  input  logic                 clk,
  input  logic                 en,
  input  logic [rgbn_pkg::Y_W-1:0] y,
  output logic [rgbn_pkg::Z_W-1:0] q
);
  import rgbn_pkg::*;

  logic [Y_W-1:0]   y_q   [DIV_STAGES];
  logic [REM_W-1:0] rem_q [DIV_STAGES];
  logic [Z_W-1:0]   quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [Y_W-1:0]   y_in;
    logic [REM_W-1:0] rem_in;
    logic [Z_W-1:0]   quo_in;
    logic [REM_W-1:0] rem_next;
    logic [Z_W-1:0]   quo_next;

    if (s == 0) begin : g_first
      assign y_in   = y;
      assign rem_in = REM_INIT;
      assign quo_in = '0;
    end else begin : g_rest
      assign y_in   = y_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] t;
      logic [Z_W-1:0]   qq;
      r  = rem_in;
      qq = quo_in;
      // Every dividend bit below the top six is a one.
      for (int b = 0; b < DIV_STEPS; b++) begin
        t = {r[REM_W-2:0], 1'b1};
        if (t >= {1'b0, y_in}) begin
          r  = t - {1'b0, y_in};
          qq = {qq[Z_W-2:0], 1'b1};
        end else begin
          r  = t;
          qq = {qq[Z_W-2:0], 1'b0};
        end
      end
      rem_next = r;
      quo_next = qq;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        y_q[s]   <= y_in;
        rem_q[s] <= rem_next;
        quo_q[s] <= quo_next;
      end
    end
  end

  assign q = quo_q[DIV_STAGES-1];

endmodule

>>> rtl/rgb_normalise_colour_correct_top.sv
// Top level of the RGB normalise and colour correct pipeline.
// Fully pipelined through eleven register stages: one beat may enter every cycle while
// the output is not stalled. The stages are normalise input, common shift, sum, five-stage
// divider, scale, multiply and add. A stalled output holds the whole pipeline. Readings of
// zero on all three channels give zero drive values with black_input set.
module rgb_normalise_colour_correct_top #(
  parameter int unsigned INPUT_WIDTH = rgbn_pkg::INPUT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // red_in, green_in, blue_in from bit 0 up, zero filled to whole bytes
  input  logic [((3*INPUT_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // red_drive, green_drive, blue_drive from bit 0 up
  output logic [23:0] m_tdata,
  // black_input
  output logic [0:0]  m_tuser
);
  import rgbn_pkg::*;

  localparam int unsigned LAT  = 11;
  localparam int unsigned POSW = $clog2(INPUT_WIDTH);

  logic            en;
  logic [LAT-1:0]  vld;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Stage 1: split and find the largest reading.
  logic [INPUT_WIDTH-1:0] raw [3];
  logic [INPUT_WIDTH-1:0] raw1 [3];
  logic [INPUT_WIDTH-1:0] top_next, top1;
  logic                   blk1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      raw[k] = s_tdata[k*INPUT_WIDTH +: INPUT_WIDTH];
    end
    top_next = raw[0];
    if (raw[1] > top_next) begin
      top_next = raw[1];
    end
    if (raw[2] > top_next) begin
      top_next = raw[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw1 <= raw;
      top1 <= top_next;
      blk1 <= (top_next == '0);
    end
  end

  // Stage 2: one common shift brings the largest reading into 127..255.
  logic [POSW-1:0] pos;
  ch_t             ch_next [3];
  ch_t             ch2 [3];
  logic            blk2;

  always_comb begin
    pos = '0;
    for (int i = 0; i < INPUT_WIDTH; i++) begin
      if (top1[i]) begin
        pos = POSW'(i);
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (pos >= POSW'(8)) begin
        ch_next[k] = CH_W'(raw1[k] >> (pos - POSW'(7)));
      end else if (top1 < INPUT_WIDTH'(TOP_LOW)) begin
        ch_next[k] = CH_W'(raw1[k] << (POSW'(7) - pos));
      end else begin
        ch_next[k] = CH_W'(raw1[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch2  <= ch_next;
      blk2 <= blk1;
    end
  end

  // Stage 3: luminance-like sum for the divider.
  logic [Y_W-1:0] y3;
  ch_t            ch3 [3];
  logic           blk3;

  always_ff @(posedge clk) begin
    if (en) begin
      y3   <= Y_W'(ch2[2]) + Y_W'(ch2[1]) + Y_W'({ch2[1], 1'b0}) + Y_W'(ch2[0]);
      ch3  <= ch2;
      blk3 <= blk2;
    end
  end

  // Stages 4 to 8: divider, channels ride alongside.
  logic [Z_W-1:0] zq;
  ch_t            chd  [DIV_STAGES][3];
  logic           blkd [DIV_STAGES];

  rgbn_div u_div (
    .clk (clk),
    .en  (en),
    .y   (y3),
    .q   (zq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      chd[0]  <= ch3;
      blkd[0] <= blk3;
      for (int s = 1; s < DIV_STAGES; s++) begin
        chd[s]  <= chd[s-1];
        blkd[s] <= blkd[s-1];
      end
    end
  end

  // Stage 9: scale each channel by the reciprocal, product wrapped to 16 bits.
  logic [SC_W-1:0] sc9 [3];
  logic            blk9;
  word_t           scaled [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      scaled[k] = word_t'(chd[DIV_STAGES-1][k]) * word_t'(zq);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sc9[k] <= scaled[k][15:6];
      end
      blk9 <= blkd[DIV_STAGES-1];
    end
  end

  // Stage 10: matrix products, wrapped to 16 bits.
  word_t prod10 [3][3];
  logic  blk10;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod10[r][k] <= 16'({6'd0, sc9[k]} * MIX_W[r][k]);
        end
      end
      blk10 <= blk9;
    end
  end

  // Stage 11: wrapped sums, drive is bits 14..7.
  word_t              sum11 [3];
  logic [DRV_W-1:0]   drv   [3];
  logic               blk11;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum11[r] = prod10[r][0] + prod10[r][1] + prod10[r][2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        drv[r] <= blk10 ? '0 : sum11[r][14:7];
      end
      blk11 <= blk10;
    end
  end

  assign m_tvalid = vld[LAT-1];
  assign m_tdata  = {drv[2], drv[1], drv[0]};
  assign m_tuser  = blk11;

endmodule

>>> rtl/rgbn_checker.sv
// Port-level checks for the RGB normalise and colour correct block, with its bind.
module rgbn_checker #(
  parameter int unsigned IN_W = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [((3*IN_W+7)/8)*8-1:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // A black beat always carries zero drive values.
  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("black beat with nonzero drive");

  // A held result stalls the whole pipeline, so no new beat enters.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  // Nothing comes out straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output beat changed");

  // An offered input beat carries fully known readings.
  a_input_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid |-> !$isunknown(s_tdata))
    else $error("input beat with unknown readings");

endmodule

bind rgb_normalise_colour_correct_top rgbn_checker #(.IN_W(INPUT_WIDTH)) u_rgbn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
